FILE: rtl/polyspiral_vertex_generator_defines.svh
// Assertion macros for the polyspiral vertex generator.
// Used by the top level; clk and arst_n must be in scope where expanded.
// Compiled out when SYNTH is defined.
`ifndef POLYSPIRAL_VERTEX_GENERATOR_DEFINES_SVH
`define POLYSPIRAL_VERTEX_GENERATOR_DEFINES_SVH

`ifndef SYNTH

`define PVG_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication check failed");

`define PVG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication check failed");

`else

`define PVG_ASSERT_IMP(label, ante, cons)

`define PVG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/pvg_pkg.sv
// Shared types, register indexes and helper functions for the polyspiral
// vertex generator: controller/datapath command and status structs.
`default_nettype none

package pvg_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_START_X       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEADING_STEP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_LENGTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH_STEP   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_TOTAL  = 3'd6;

	// CORDIC gain compensation, Q4.30
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef struct packed {
		logic load_start;
		logic rot_init;
		logic rot_step;
		logic mul_cos;
		logic mul_sin;
		logic commit;
		logic emit;
		logic emit_done;
	} pvg_cmd_t;

	typedef struct packed {
		logic started;
		logic exhausted;
		logic rot_last;
	} pvg_stat_t;

	// arctangent of 2^-i in 2^-32 turn units
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:    r = 32'h20000000;
			5'd1:    r = 32'h12E4051E;
			5'd2:    r = 32'h09FB385B;
			5'd3:    r = 32'h051111D4;
			5'd4:    r = 32'h028B0D43;
			5'd5:    r = 32'h0145D7E1;
			5'd6:    r = 32'h00A2F61E;
			5'd7:    r = 32'h00517C55;
			5'd8:    r = 32'h0028BE53;
			5'd9:    r = 32'h00145F2F;
			5'd10:   r = 32'h000A2F98;
			5'd11:   r = 32'h000517CC;
			5'd12:   r = 32'h00028BE6;
			5'd13:   r = 32'h000145F3;
			5'd14:   r = 32'h0000A2FA;
			5'd15:   r = 32'h0000517D;
			5'd16:   r = 32'h000028BE;
			5'd17:   r = 32'h0000145F;
			5'd18:   r = 32'h00000A30;
			5'd19:   r = 32'h00000518;
			5'd20:   r = 32'h0000028C;
			5'd21:   r = 32'h00000146;
			5'd22:   r = 32'h000000A3;
			5'd23:   r = 32'h00000051;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [35:0] v);
		logic [31:0] r;
		if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
			r = v[31:0];
		end else if (v[35]) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'h7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/pvg_ctrl.sv
// Sequencing controller for the polyspiral vertex generator.
// Drives pvg_datapath through pvg_cmd_t and owns both channel handshakes.
`default_nettype none

module pvg_ctrl
	import pvg_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire logic      restart,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire pvg_stat_t stat,
	output pvg_cmd_t       cmd
);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_START   = 7'b0000010,
		ST_ROTATE  = 7'b0000100,
		ST_MUL_COS = 7'b0001000,
		ST_MUL_SIN = 7'b0010000,
		ST_COMMIT  = 7'b0100000,
		ST_EMIT    = 7'b1000000
	} pvg_state_t;

	pvg_state_t state_q, state_d;
	logic       done_q, done_d;
	logic       out_valid_q;
	logic       fresh;
	logic       emit_ok;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign fresh     = restart || !stat.started;
	assign emit_ok   = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		done_d  = done_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					done_d = !fresh && stat.exhausted;
					if (fresh) begin
						state_d = ST_START;
					end else if (stat.exhausted) begin
						state_d = ST_EMIT;
					end else begin
						cmd.rot_init = 1'b1;
						state_d      = ST_ROTATE;
					end
				end
			end
			ST_START: begin
				cmd.load_start = 1'b1;
				state_d        = ST_EMIT;
			end
			ST_ROTATE: begin
				cmd.rot_step = 1'b1;
				if (stat.rot_last) begin
					state_d = ST_MUL_COS;
				end
			end
			ST_MUL_COS: begin
				cmd.mul_cos = 1'b1;
				state_d     = ST_MUL_SIN;
			end
			ST_MUL_SIN: begin
				cmd.mul_sin = 1'b1;
				state_d     = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_ok) begin
					cmd.emit      = 1'b1;
					cmd.emit_done = done_q;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pvg_datapath.sv
// Datapath of the polyspiral vertex generator: config registers, turtle
// state, iterative CORDIC, shared multiplier and output register. Uses pvg_pkg.
`default_nettype none

module pvg_datapath
	import pvg_pkg::*;
#(
	parameter int CORDIC_ITERATIONS = 16,
	parameter int ANGLE_BITS        = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire pvg_cmd_t             cmd,
	output pvg_stat_t                 stat,
	output logic signed [31:0]        vertex_x,
	output logic signed [31:0]        vertex_y,
	output logic [15:0]               vertex_index,
	output logic                      is_last,
	output logic                      exhausted
);

	localparam int IW  = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
	localparam int ASH = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
	localparam int RSH = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
	localparam logic signed [64:0] RND_HALF = 65'sd536870912;

	// configuration
	logic signed [31:0] start_x_q, start_y_q, start_length_q, length_step_q;
	logic [15:0]        start_heading_q, heading_step_q, vertex_total_q;

	// turtle state
	logic signed [31:0]    pos_x_q, pos_y_q, len_q;
	logic [ANGLE_BITS-1:0] heading_q;
	logic [15:0]           cnt_q;
	logic                  started_q;

	// CORDIC and multiplier
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic               flip_q;
	logic [IW-1:0]      iter_q;
	logic signed [64:0] prod_q;

	logic [ANGLE_BITS-1:0] start_heading_sc, heading_step_sc;
	logic [15:0]           total;
	logic [31:0]           ang32;
	logic                  flip_w;
	logic signed [33:0]    z_init, dx, dy, atan_s, cos_v, sin_v;
	logic signed [32:0]    mul_op;
	logic signed [64:0]    mul_w, prod_rnd;
	logic signed [34:0]    offset;
	logic signed [35:0]    pos_x_sum, pos_y_sum, len_sum;

	assign start_heading_sc = ANGLE_BITS'(({24'd0, start_heading_q} << ASH) >> RSH);
	assign heading_step_sc  = ANGLE_BITS'(({24'd0, heading_step_q} << ASH) >> RSH);
	assign total            = (vertex_total_q == 16'd0) ? 16'd1 : vertex_total_q;

	assign stat.started   = started_q;
	assign stat.exhausted = (cnt_q >= total);
	assign stat.rot_last  = (iter_q == IW'(CORDIC_ITERATIONS - 1));

	// fold heading into [-quarter, +quarter] turn
	assign ang32  = {heading_q, {(32 - ANGLE_BITS){1'b0}}};
	assign flip_w = ang32[31] ^ ang32[30];
	assign z_init = $signed({{3{ang32[31] ^ flip_w}}, ang32[30:0]});

	assign dx     = cx_q >>> iter_q;
	assign dy     = cy_q >>> iter_q;
	assign atan_s = $signed({2'b00, atan_turn(5'(iter_q))});

	assign cos_v  = flip_q ? -cx_q : cx_q;
	assign sin_v  = flip_q ? -cy_q : cy_q;
	assign mul_op = cmd.mul_sin ? sin_v[32:0] : cos_v[32:0];
	assign mul_w  = 65'(len_q) * 65'(mul_op);

	assign prod_rnd  = prod_q + RND_HALF;
	assign offset    = prod_rnd[64:30];
	assign pos_x_sum = 36'(pos_x_q) + 36'(offset);
	assign pos_y_sum = 36'(pos_y_q) + 36'(offset);
	assign len_sum   = 36'(len_q) + 36'(length_step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q       <= '0;
			start_y_q       <= '0;
			start_heading_q <= '0;
			heading_step_q  <= '0;
			start_length_q  <= 32'sd65536;
			length_step_q   <= '0;
			vertex_total_q  <= 16'd1;
			cnt_q           <= '0;
			started_q       <= 1'b0;
			iter_q          <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_START_X:       start_x_q       <= cfg_data;
					REG_START_Y:       start_y_q       <= cfg_data;
					REG_START_HEADING: start_heading_q <= cfg_data[15:0];
					REG_HEADING_STEP:  heading_step_q  <= cfg_data[15:0];
					REG_START_LENGTH:  start_length_q  <= cfg_data;
					REG_LENGTH_STEP:   length_step_q   <= cfg_data;
					REG_VERTEX_TOTAL:  vertex_total_q  <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.load_start) begin
				cnt_q     <= 16'd1;
				started_q <= 1'b1;
			end else if (cmd.commit) begin
				cnt_q <= 16'(cnt_q + 16'd1);
			end
			if (cmd.rot_init) begin
				iter_q <= '0;
			end else if (cmd.rot_step && !stat.rot_last) begin
				iter_q <= IW'(iter_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_start) begin
			pos_x_q   <= start_x_q;
			pos_y_q   <= start_y_q;
			heading_q <= start_heading_sc;
			len_q     <= start_length_q;
		end
		if (cmd.rot_init) begin
			cx_q   <= CORDIC_GAIN;
			cy_q   <= '0;
			cz_q   <= z_init;
			flip_q <= flip_w;
		end else if (cmd.rot_step) begin
			if (!cz_q[33]) begin
				cx_q <= cx_q - dy;
				cy_q <= cy_q + dx;
				cz_q <= cz_q - atan_s;
			end else begin
				cx_q <= cx_q + dy;
				cy_q <= cy_q - dx;
				cz_q <= cz_q + atan_s;
			end
		end
		if (cmd.mul_cos || cmd.mul_sin) begin
			prod_q <= mul_w;
		end
		if (cmd.mul_sin) begin
			pos_x_q <= sat32(pos_x_sum);
		end
		if (cmd.commit) begin
			pos_y_q   <= sat32(pos_y_sum);
			len_q     <= sat32(len_sum);
			heading_q <= ANGLE_BITS'(heading_q + heading_step_sc);
		end
		if (cmd.emit) begin
			vertex_x     <= pos_x_q;
			vertex_y     <= pos_y_q;
			vertex_index <= 16'(cnt_q - 16'd1);
			is_last      <= !cmd.emit_done && (cnt_q == total);
			exhausted    <= cmd.emit_done;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/polyspiral_vertex_generator.sv
// Top level of the polyspiral vertex generator: pvg_ctrl and pvg_datapath.
// Depends on pvg_pkg and polyspiral_vertex_generator_defines.svh.
//
// Returns one vertex per request on a valid/ready channel. A request with
// restart set, or the first one after reset, loads the start point in
// ST_START and returns it from ST_EMIT; a request past the end of the spiral
// goes straight to ST_EMIT and returns the last vertex again. A move runs
// through ST_ROTATE, ST_MUL_COS, ST_MUL_SIN, ST_COMMIT and ST_EMIT, the
// CORDIC unit doing one micro-rotation per cycle followed by one shared
// 32x33 multiplier used for cosine and then sine. One request is in work at
// a time; the next is taken as soon as the previous result sits in the output
// register, even if it has not yet been transferred out. Start values take
// effect on the next restart, the step values and vertex_total on the next
// request. Configuration writes must only be made while the block is idle.
`default_nettype none

`include "polyspiral_vertex_generator_defines.svh"

module polyspiral_vertex_generator
	import pvg_pkg::*;
#(
	parameter int CORDIC_ITERATIONS = 16,
	parameter int ANGLE_BITS        = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 restart,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [31:0]        vertex_x,
	output logic signed [31:0]        vertex_y,
	output logic [15:0]               vertex_index,
	output logic                      is_last,
	output logic                      exhausted
);

	pvg_cmd_t  cmd;
	pvg_stat_t stat;

	pvg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.restart   (restart),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pvg_datapath #(
		.CORDIC_ITERATIONS (CORDIC_ITERATIONS),
		.ANGLE_BITS        (ANGLE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.vertex_index (vertex_index),
		.is_last      (is_last),
		.exhausted    (exhausted)
	);

	`PVG_ASSERT_NEXT(a_busy_after_xfer, in_valid && in_ready, !in_ready)
	`PVG_ASSERT_IMP(a_last_not_done, out_valid && is_last, !exhausted)
	`PVG_ASSERT_IMP(a_result_needs_req, $rose(out_valid), $past(!in_ready))
	`PVG_ASSERT_IMP(a_emit_only_when_free, cmd.emit, !out_valid || out_ready)

endmodule

`default_nettype wire
